// ===== sv/ipru_pkg.sv =====
package ipru_pkg;

	localparam int SCALE_W = 7;
	localparam int SWIDTH_W = 12;
	localparam int PASS_W = 6;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_FACTOR = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH = 1'd1;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	// one source pixel on its way to the output repeater
	typedef struct packed {
		logic err;
		logic last_col;
		pix_t pix;
	} rep_item_t;

endpackage

// ===== sv/ipru_ram.sv =====
module ipru_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/ipru_repeat.sv =====
module ipru_repeat
	import ipru_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load_valid,
	output logic               load_ready,
	input  rep_item_t          load_item,
	input  logic [SCALE_W-1:0] scale,
	input  logic [1:0]         pad,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [7:0]         blue_out,
	output logic [7:0]         green_out,
	output logic [7:0]         red_out,
	output logic [1:0]         pad_bytes,
	output logic               row_end,
	output logic               run_last,
	output logic               op_error
);

	logic               valid_q;
	rep_item_t          item_q;
	logic [SCALE_W-1:0] cnt_q;
	logic               last_copy;
	logic               take;
	logic               done;

	assign last_copy = (cnt_q + SCALE_W'(1)) == scale;
	assign take = valid_q && !result_stall;
	assign done = take && (item_q.err || last_copy);
	assign load_ready = !valid_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (load_valid && load_ready) begin
				valid_q <= 1'b1;
				cnt_q <= '0;
			end else if (done) begin
				valid_q <= 1'b0;
			end else if (take) begin
				cnt_q <= cnt_q + SCALE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			item_q <= load_item;
		end
	end

	assign result_valid = valid_q;
	assign blue_out = item_q.err ? 8'd0 : item_q.pix.blue;
	assign green_out = item_q.err ? 8'd0 : item_q.pix.green;
	assign red_out = item_q.err ? 8'd0 : item_q.pix.red;
	assign row_end = !item_q.err && last_copy && item_q.last_col;
	assign pad_bytes = row_end ? pad : 2'd0;
	assign run_last = item_q.err || last_copy;
	assign op_error = item_q.err;

endmodule

// ===== sv/integer_pixel_replication_upscaler.sv =====
// Integer pixel replication upscaler for 24-bit BGR rows.
// Pixel channel (pixel_valid / pixel_stall): op=0 brings a new source pixel on the
// first pass of a row, op=1 replays the next buffered pixel on the other passes.
// Result channel (result_valid / result_stall): every request whose op fits the pass
// gives scale_factor copies of its pixel; run_last marks the final copy, row_end and
// pad_bytes mark the end of an output row. A request whose op does not fit the pass
// gives one result with op_error set and leaves the position unchanged.
// Config port: cfg_we, cfg_index, cfg_data; index 0 is scale_factor, index 1 is
// source_width. A write also restarts the source row. Write only while idle.
// A taken request passes through the stage-1 register and then the repeater register
// before result_valid rises; a busy repeater can hold it in stage 1.
// Throughput: one result per cycle while result_stall is low; a request occupies the
// result repeater until its copies are taken, the effective scale factor (0 counts as
// 1, above 64 as 64) of them or one for an error, which sets the sustained request rate.
// A second request can wait in the input register while the repeater drains.
// A stalled receiver holds the current result; requests back up into the input
// register and then pixel_stall rises.
// Reset clears the pipeline, the row position and the registers (scale 1, width 1).
// The line buffer has no reset; replays only read entries written in the same row.
module integer_pixel_replication_upscaler
	import ipru_pkg::*;
#(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_SCALE = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   pixel_valid,
	output logic                   pixel_stall,
	input  logic                   op,
	input  logic [7:0]             blue_in,
	input  logic [7:0]             green_in,
	input  logic [7:0]             red_in,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic [7:0]             blue_out,
	output logic [7:0]             green_out,
	output logic [7:0]             red_out,
	output logic [1:0]             pad_bytes,
	output logic                   row_end,
	output logic                   run_last,
	output logic                   op_error
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CMPW = 18;

	logic [SCALE_W-1:0]  scale_factor_q;
	logic [SWIDTH_W-1:0] source_width_q;
	logic [AW-1:0]       col_q;
	logic [PASS_W-1:0]   pass_q;

	logic [SCALE_W-1:0]  scale_eff;
	logic [CMPW-1:0]     width_eff;
	logic [CMPW-1:0]     col_next;
	logic [SCALE_W-1:0]  pass_next;
	logic                last_col;
	logic                err;
	logic                accept;
	logic [1:0]          prod3;
	logic [1:0]          pad;
	pix_t                pix_in;

	logic      valid_s1;
	logic      err_s1;
	logic      replay_s1;
	logic      last_col_s1;
	pix_t      pix_s1;
	pix_t      rdata;
	rep_item_t rep_item;
	logic      rep_ready;

	always_comb begin
		if (scale_factor_q == '0) begin
			scale_eff = SCALE_W'(1);
		end else if (scale_factor_q > SCALE_W'(MAX_SCALE)) begin
			scale_eff = SCALE_W'(MAX_SCALE);
		end else begin
			scale_eff = scale_factor_q;
		end
		if (source_width_q == '0) begin
			width_eff = CMPW'(1);
		end else if (CMPW'(source_width_q) > CMPW'(MAX_WIDTH)) begin
			width_eff = CMPW'(MAX_WIDTH);
		end else begin
			width_eff = CMPW'(source_width_q);
		end
	end

	// row bytes mod 4 only depend on the low bits of width and scale
	assign prod3 = 2'(width_eff[1:0] * scale_eff[1:0] * 2'd3);
	assign pad = 2'd0 - prod3;

	assign col_next = CMPW'(col_q) + CMPW'(1);
	assign last_col = col_next >= width_eff;
	assign pass_next = SCALE_W'(pass_q) + SCALE_W'(1);
	assign err = (op == 1'b0) != (pass_q == '0);

	assign pix_in = '{red: red_in, green: green_in, blue: blue_in};

	assign pixel_stall = valid_s1 && !rep_ready;
	assign accept = pixel_valid && !pixel_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_factor_q <= SCALE_W'(1);
			source_width_q <= SWIDTH_W'(1);
			col_q <= '0;
			pass_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SCALE_FACTOR: begin
						scale_factor_q <= cfg_data[SCALE_W-1:0];
						col_q <= '0;
						pass_q <= '0;
					end
					CFG_SOURCE_WIDTH: begin
						source_width_q <= cfg_data[SWIDTH_W-1:0];
						col_q <= '0;
						pass_q <= '0;
					end
					default: begin
					end
				endcase
			end else if (accept && !err) begin
				if (last_col) begin
					col_q <= '0;
					pass_q <= (pass_next >= scale_eff) ? '0 : pass_next[PASS_W-1:0];
				end else begin
					col_q <= col_next[AW-1:0];
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (rep_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_s1 <= err;
			replay_s1 <= op;
			last_col_s1 <= last_col;
			pix_s1 <= pix_in;
		end
	end

	ipru_ram #(
		.WIDTH($bits(pix_t)),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (accept && !err && !op),
		.waddr(col_q),
		.wdata(pix_in),
		.re   (accept && !err && op),
		.raddr(col_q),
		.rdata(rdata)
	);

	// read data holds until the next replay request, so it stays with stage 1
	assign rep_item = '{
		err: err_s1,
		last_col: last_col_s1,
		pix: replay_s1 ? rdata : pix_s1
	};

	ipru_repeat u_repeat (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_valid  (valid_s1),
		.load_ready  (rep_ready),
		.load_item   (rep_item),
		.scale       (scale_eff),
		.pad         (pad),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.blue_out    (blue_out),
		.green_out   (green_out),
		.red_out     (red_out),
		.pad_bytes   (pad_bytes),
		.row_end     (row_end),
		.run_last    (run_last),
		.op_error    (op_error)
	);

endmodule

// ===== sim/tb_integer_pixel_replication_upscaler.sv =====
`timescale 1ns / 100ps

module tb_integer_pixel_replication_upscaler;
	import ipru_pkg::*;

	localparam int LINE_DEPTH = 2048;
	localparam int LINE_AW = $clog2(LINE_DEPTH);
	localparam int SCALE_LIMIT = 64;
	localparam int RANDOM_REQUESTS = 91;
	localparam int IDLE_PCT = 27;
	localparam int unsigned CYCLE_LIMIT = 200000;

	typedef enum logic {
		OP_NEW = 1'b0,
		OP_REPLAY = 1'b1
	} op_e;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [1:0] pad;
		logic       row_end;
		logic       run_last;
		logic       op_error;
	} upscaled_pix_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_SCALE_FACTOR;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   pixel_valid = 1'b0;
	logic                   pixel_stall;
	logic                   op = OP_NEW;
	logic [7:0]             blue_in = '0;
	logic [7:0]             green_in = '0;
	logic [7:0]             red_in = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	logic [7:0]             blue_out;
	logic [7:0]             green_out;
	logic [7:0]             red_out;
	logic [1:0]             pad_bytes;
	logic                   row_end;
	logic                   run_last;
	logic                   op_error;

	// mirror of the block state
	pix_t                line_mirror [LINE_DEPTH];
	int unsigned         col_pos = 0;
	int unsigned         pass_pos = 0;
	logic [SCALE_W-1:0]  scale_setting = SCALE_W'(1);
	logic [SWIDTH_W-1:0] width_setting = SWIDTH_W'(1);

	upscaled_pix_t pending_copies[$];
	int unsigned   mismatch_count = 0;
	int unsigned   cycle_count = 0;
	bit            gaps_on = 1'b1;

	integer_pixel_replication_upscaler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.op           (op),
		.blue_in      (blue_in),
		.green_in     (green_in),
		.red_in       (red_in),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.blue_out     (blue_out),
		.green_out    (green_out),
		.red_out      (red_out),
		.pad_bytes    (pad_bytes),
		.row_end      (row_end),
		.run_last     (run_last),
		.op_error     (op_error)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_integer_pixel_replication_upscaler: FAIL");
			$finish;
		end
	end

	always @(negedge clk) begin
		result_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
	end

	task automatic predict_replication(input op_e kind, input pix_t px);
		int unsigned   s;
		int unsigned   w;
		int unsigned   pad;
		bit            last_col;
		upscaled_pix_t copy;
		s = (scale_setting == 0) ? 1 : (scale_setting > SCALE_LIMIT ? SCALE_LIMIT : scale_setting);
		w = (width_setting == 0) ? 1 : (width_setting > LINE_DEPTH ? LINE_DEPTH : width_setting);
		copy = '0;
		if ((kind == OP_NEW) != (pass_pos == 0)) begin
			copy.run_last = 1'b1;
			copy.op_error = 1'b1;
			pending_copies.push_back(copy);
			return;
		end
		if (kind == OP_NEW)
			line_mirror[LINE_AW'(col_pos)] = px;
		else
			px = line_mirror[LINE_AW'(col_pos)];
		last_col = (col_pos + 1 >= w);
		pad = (4 - (w * s * 3) % 4) % 4;
		copy.blue = px.blue;
		copy.green = px.green;
		copy.red = px.red;
		for (int k = 0; k < s; k++) begin
			copy.run_last = (k + 1 == s);
			copy.row_end = copy.run_last && last_col;
			copy.pad = copy.row_end ? pad[1:0] : 2'd0;
			pending_copies.push_back(copy);
		end
		if (last_col) begin
			col_pos = 0;
			pass_pos++;
			if (pass_pos >= s)
				pass_pos = 0;
		end else begin
			col_pos++;
		end
	endtask

	// called at a falling edge, returns at a falling edge with valid still high
	task automatic send_request(input op_e kind, input pix_t px);
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			pixel_valid <= 1'b0;
			@(negedge clk);
		end
		pixel_valid <= 1'b1;
		op <= kind;
		blue_in <= px.blue;
		green_in <= px.green;
		red_in <= px.red;
		do
			@(posedge clk);
		while (pixel_stall);
		predict_replication(kind, px);
		@(negedge clk);
	endtask

	task automatic settle();
		pixel_valid <= 1'b0;
		while (pending_copies.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_SCALE_FACTOR)
			scale_setting = val[SCALE_W-1:0];
		else
			width_setting = val;
		col_pos = 0;
		pass_pos = 0;
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		upscaled_pix_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_copies.size() == 0) begin
				$error("result with no request pending");
				mismatch_count++;
			end else begin
				want = pending_copies.pop_front();
				check_field("blue_out", want.blue, blue_out);
				check_field("green_out", want.green, green_out);
				check_field("red_out", want.red, red_out);
				check_field("pad_bytes", 8'(want.pad), 8'(pad_bytes));
				check_field("row_end", 8'(want.row_end), 8'(row_end));
				check_field("run_last", 8'(want.run_last), 8'(run_last));
				check_field("op_error", 8'(want.op_error), 8'(op_error));
			end
		end
	end

	// defaults after reset: scale 1, width 1
	task automatic test_reset_state();
		send_request(OP_REPLAY, 24'h000000);
		send_request(OP_NEW, 24'h000000);
		send_request(OP_NEW, 24'hFFFFFF);
	endtask

	task automatic test_wrong_op();
		write_reg(CFG_SCALE_FACTOR, 12'd2);
		write_reg(CFG_SOURCE_WIDTH, 12'd2);
		send_request(OP_REPLAY, 24'h123456);
		send_request(OP_NEW, 24'h0A0B0C);
		send_request(OP_NEW, 24'hC0B0A0);
		// replay pass now, a new pixel is rejected
		send_request(OP_NEW, 24'hFFFFFF);
		send_request(OP_REPLAY, 24'hFFFFFF);
		send_request(OP_REPLAY, 24'h000000);
		send_request(OP_NEW, 24'h808080);
	endtask

	task automatic test_pixel_bits();
		write_reg(CFG_SCALE_FACTOR, 12'd1);
		write_reg(CFG_SOURCE_WIDTH, 12'd4);
		send_request(OP_NEW, 24'h55AA55);
		send_request(OP_NEW, 24'hAA55AA);
	endtask

	task automatic test_config_limits();
		write_reg(CFG_SCALE_FACTOR, 12'd0);
		write_reg(CFG_SOURCE_WIDTH, 12'd0);
		send_request(OP_NEW, 24'h010203);
		// all data bits set: scale field 127, width 4095, both clamp
		write_reg(CFG_SCALE_FACTOR, 12'hFFF);
		write_reg(CFG_SOURCE_WIDTH, 12'hFFF);
		send_request(OP_NEW, 24'hFEDCBA);
		write_reg(CFG_SCALE_FACTOR, 12'd100);
		write_reg(CFG_SOURCE_WIDTH, 12'd2048);
		send_request(OP_NEW, 24'h7F7F7F);
		write_reg(CFG_SCALE_FACTOR, 12'd64);
		write_reg(CFG_SOURCE_WIDTH, 12'd1);
		send_request(OP_NEW, 24'h3C5A96);
		send_request(OP_REPLAY, 24'h000000);
		send_request(OP_REPLAY, 24'hFFFFFF);
		// a write mid-row restarts at the first pass
		write_reg(CFG_SOURCE_WIDTH, 12'd3);
		send_request(OP_REPLAY, 24'h111111);
	endtask

	task automatic test_random_rows();
		int unsigned issued;
		int unsigned phase;
		int unsigned n;
		int unsigned r;
		logic [SCALE_W-1:0]  s;
		logic [SWIDTH_W-1:0] w;
		op_e kind;
		issued = 0;
		phase = 0;
		while (issued < RANDOM_REQUESTS) begin
			r = $urandom_range(99);
			if (r < 8)
				s = '0;
			else if (r < 14)
				s = SCALE_W'($urandom_range(65, 127));
			else
				s = SCALE_W'($urandom_range(1, 6));
			r = $urandom_range(99);
			if (r < 8)
				w = '0;
			else if (r < 12)
				w = SWIDTH_W'($urandom_range(2049, 4095));
			else
				w = SWIDTH_W'($urandom_range(1, 8));
			if ($urandom_range(1)) begin
				write_reg(CFG_SCALE_FACTOR, {5'($urandom), s});
				write_reg(CFG_SOURCE_WIDTH, w);
			end else begin
				write_reg(CFG_SOURCE_WIDTH, w);
				write_reg(CFG_SCALE_FACTOR, {5'($urandom), s});
			end
			gaps_on = (phase != 2);
			n = (phase == 2) ? 25 : $urandom_range(6, 24);
			repeat (n) begin
				if (issued < RANDOM_REQUESTS) begin
					// mostly well-formed rows, some requests with the wrong op
					if ($urandom_range(99) < 10)
						kind = (pass_pos == 0) ? OP_REPLAY : OP_NEW;
					else
						kind = (pass_pos == 0) ? OP_NEW : OP_REPLAY;
					send_request(kind, 24'($urandom));
					issued++;
				end
			end
			phase++;
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_state();
		test_wrong_op();
		test_pixel_bits();
		test_config_limits();
		test_random_rows();
		settle();
		repeat (20) @(negedge clk);
		if (mismatch_count == 0 && pending_copies.size() == 0)
			$display("tb_integer_pixel_replication_upscaler: PASS");
		else
			$display("tb_integer_pixel_replication_upscaler: FAIL");
		$finish;
	end

endmodule
